/* hw/rtl/gita_pkg.sv */
// gita_pkg: shared constants and codes for the greedy IoU track association block.
// No dependencies.
`timescale 1ns / 1ps
package gita_pkg;
    localparam logic OP_DET = 1'b0;
    localparam logic OP_EOF = 1'b1;
    localparam logic CFG_IOU_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_MISSED    = 1'b1;
    localparam int   IDENT_BITS  = 16;
    localparam int   MISS_BITS   = 9;
    localparam logic [7:0] IOU_THRESHOLD_RST = 8'd77;
    localparam logic [7:0] MAX_MISSED_RST    = 8'd8;
endpackage

/* hw/rtl/greedy_iou_track_association.sv */
// greedy_iou_track_association: track table, sequencer and shared multiplier.
// Depends on gita_pkg.
`timescale 1ns / 1ps
// Usage
//   Input channel s_*: one request carries op and a box. op 0 = detection,
//   op 1 = end of frame. The block takes one request at a time; s_ready is low
//   while a request is being worked on and while a result waits.
//   Result channel m_*: one result per detection (id, new_track,
//   table_full); end-of-frame requests give no result.
//   Sequence: a detection walks the slots one by one through a shared
//   multiplier: the detection area first; then per live unused slot the
//   intersection, the track area and, if they overlap, the threshold
//   products and, if it clears them, the best-so-far cross products; then
//   the table is settled. End of frame holds s_ready low while it ages
//   every slot in turn. Every area and cross product passes the multiplier.
//   Config: cfg_we/cfg_idx/cfg_wdata; the user must write only while idle,
//   the block itself does not enforce it. Reset (aresetn low, synchronous):
//   all slots invalid, ids restart at 0, registers back to 77 and 8.
//   Receiver stall: the result is held in m_* until m_ready; no new request
//   is taken meanwhile.
module greedy_iou_track_association #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_idx,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [COORD_BITS-1:0] s_box_x,
    input  logic [COORD_BITS-1:0] s_box_y,
    input  logic [COORD_BITS-1:0] s_box_w,
    input  logic [COORD_BITS-1:0] s_box_h,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_trk_ident,
    output logic                  m_new_track,
    output logic                  m_table_full
);
    localparam int SW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW = COORD_BITS + 1;       // edge sums
    localparam int AW = 2 * COORD_BITS;       // areas
    localparam int UW = AW + 1;               // union
    localparam int MW = 2 * UW + 9;           // cross products
    localparam int BW = 4 * COORD_BITS;
    localparam logic [SW:0] LAST = (SW+1)'(MAX_TRACKS - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_AREA  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_INTER = 4'd3;
    localparam logic [3:0] ST_TAREA = 4'd4;
    localparam logic [3:0] ST_THR_L = 4'd5;
    localparam logic [3:0] ST_THR_R = 4'd6;
    localparam logic [3:0] ST_BST_L = 4'd7;
    localparam logic [3:0] ST_BST_R = 4'd8;
    localparam logic [3:0] ST_NEXT  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;
    localparam logic [3:0] ST_AGE   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [SW:0] slot_reg;
    logic [MAX_TRACKS-1:0] valid_reg, used_reg;
    logic [BW-1:0] box_mem [MAX_TRACKS];
    logic [gita_pkg::MISS_BITS-1:0] miss_mem [MAX_TRACKS];
    logic [gita_pkg::IDENT_BITS-1:0] ident_mem [MAX_TRACKS];
    logic [gita_pkg::IDENT_BITS-1:0] next_ident_reg;
    logic [7:0] thr_reg, maxm_reg;

    logic [COORD_BITS-1:0] dx_reg, dy_reg, dw_reg, dh_reg;
    logic [BW-1:0] tbox_reg;
    logic [AW-1:0] area_reg, inter_reg, tarea_reg;
    logic [UW-1:0] uni_reg;
    logic [MW-1:0] lhs_reg, prod;
    logic [AW-1:0] best_inter_reg;
    logic [UW-1:0] best_union_reg;
    logic best_found_reg;
    logic [SW-1:0] best_slot_reg;
    logic [UW-1:0] mul_a;
    logic [UW+8-1:0] mul_b;

    logic [COORD_BITS-1:0] tx, ty, tw, th, ox, oy;
    logic [CW-1:0] sx, sy, ex, ey, e1x, e2x, e1y, e2y;
    logic [SW-1:0] si;
    logic slot_live, have_free;
    logic [SW-1:0] free_slot;

    assign si = slot_reg[SW-1:0];
    assign tx = tbox_reg[COORD_BITS-1:0];
    assign ty = tbox_reg[2*COORD_BITS-1:COORD_BITS];
    assign tw = tbox_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign th = tbox_reg[4*COORD_BITS-1:3*COORD_BITS];
    assign slot_live = valid_reg[si] && !used_reg[si];

    // 1-D overlaps of detection and held track box
    always_comb begin
        sx  = (dx_reg > tx) ? CW'(dx_reg) : CW'(tx);
        sy  = (dy_reg > ty) ? CW'(dy_reg) : CW'(ty);
        e1x = CW'(dx_reg) + CW'(dw_reg);
        e2x = CW'(tx) + CW'(tw);
        e1y = CW'(dy_reg) + CW'(dh_reg);
        e2y = CW'(ty) + CW'(th);
        ex  = (e1x < e2x) ? e1x : e2x;
        ey  = (e1y < e2y) ? e1y : e2y;
        ox  = (ex > sx) ? COORD_BITS'(ex - sx) : '0;
        oy  = (ey > sy) ? COORD_BITS'(ey - sy) : '0;
    end

    // lowest free slot
    always_comb begin
        have_free = 1'b0;
        free_slot = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                have_free = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    // the shared multiplier, operands picked by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_AREA:  begin mul_a = UW'(dw_reg); mul_b = (UW+8)'(dh_reg); end
            ST_INTER: begin mul_a = UW'(ox);     mul_b = (UW+8)'(oy);     end
            ST_TAREA: begin mul_a = UW'(tw);     mul_b = (UW+8)'(th);     end
            ST_THR_L: begin mul_a = UW'(inter_reg); mul_b = (UW+8)'(9'd256); end
            ST_THR_R: begin mul_a = uni_reg;     mul_b = (UW+8)'(thr_reg); end
            ST_BST_L: begin mul_a = UW'(inter_reg); mul_b = (UW+8)'(best_union_reg); end
            ST_BST_R: begin mul_a = uni_reg;     mul_b = (UW+8)'(best_inter_reg); end
            default:  begin mul_a = '0;          mul_b = '0;              end
        endcase
        prod = MW'(mul_a) * MW'(mul_b);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = (s_op == gita_pkg::OP_EOF) ? ST_AGE : ST_AREA;
            ST_AREA:  state_next = ST_RD;
            ST_RD:    state_next = slot_live ? ST_INTER : ST_NEXT;
            ST_INTER: state_next = ST_TAREA;
            ST_TAREA: state_next = (inter_reg == '0) ? ST_NEXT : ST_THR_L;
            ST_THR_L: state_next = ST_THR_R;
            ST_THR_R: state_next = (lhs_reg > prod) ? ST_BST_L : ST_NEXT;
            ST_BST_L: state_next = ST_BST_R;
            ST_BST_R: state_next = ST_NEXT;
            ST_NEXT:  state_next = (slot_reg == LAST) ? ST_DONE : ST_RD;
            ST_DONE:  state_next = ST_OUT;
            ST_AGE:   if (slot_reg == LAST) state_next = ST_IDLE;
            ST_OUT:   if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            used_reg       <= '0;
            next_ident_reg <= '0;
            thr_reg        <= gita_pkg::IOU_THRESHOLD_RST;
            maxm_reg       <= gita_pkg::MAX_MISSED_RST;
            slot_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    gita_pkg::CFG_IOU_THRESHOLD: thr_reg  <= cfg_wdata;
                    gita_pkg::CFG_MAX_MISSED:    maxm_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: slot_reg <= '0;
                ST_NEXT: slot_reg <= slot_reg + 1'b1;
                ST_AGE: begin
                    if (valid_reg[si] && !used_reg[si]) begin
                        if ((miss_mem[si] + 1'b1) > {1'b0, maxm_reg})
                            valid_reg[si] <= 1'b0;
                    end
                    used_reg[si] <= 1'b0;
                    slot_reg <= slot_reg + 1'b1;
                end
                ST_DONE: begin
                    if (best_found_reg) begin
                        used_reg[best_slot_reg] <= 1'b1;
                    end else if (have_free) begin
                        valid_reg[free_slot] <= 1'b1;
                        used_reg[free_slot]  <= 1'b1;
                        next_ident_reg       <= next_ident_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath and slot stores
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                dx_reg <= s_box_x; dy_reg <= s_box_y;
                dw_reg <= s_box_w; dh_reg <= s_box_h;
                best_found_reg <= 1'b0;
                best_inter_reg <= '0;
                best_union_reg <= UW'(1);
                best_slot_reg  <= '0;
            end
            ST_AREA:  area_reg  <= AW'(prod);
            ST_RD:    tbox_reg  <= box_mem[si];
            ST_INTER: inter_reg <= AW'(prod);
            ST_TAREA: uni_reg   <= UW'(area_reg) + UW'(prod) - UW'(inter_reg);
            ST_THR_L: lhs_reg   <= prod;
            ST_BST_L: lhs_reg   <= prod;
            ST_BST_R: begin
                if (lhs_reg > prod) begin
                    best_found_reg <= 1'b1;
                    best_inter_reg <= inter_reg;
                    best_union_reg <= uni_reg;
                    best_slot_reg  <= si;
                end
            end
            ST_AGE: begin
                if (valid_reg[si] && !used_reg[si])
                    miss_mem[si] <= miss_mem[si] + 1'b1;
            end
            ST_DONE: begin
                m_new_track  <= 1'b0;
                m_table_full <= 1'b0;
                if (best_found_reg) begin
                    box_mem[best_slot_reg]  <= {dh_reg, dw_reg, dy_reg, dx_reg};
                    miss_mem[best_slot_reg] <= '0;
                    m_trk_ident <= ident_mem[best_slot_reg];
                end else if (have_free) begin
                    box_mem[free_slot]   <= {dh_reg, dw_reg, dy_reg, dx_reg};
                    miss_mem[free_slot]  <= '0;
                    ident_mem[free_slot] <= next_ident_reg;
                    m_trk_ident <= next_ident_reg;
                    m_new_track <= 1'b1;
                end else begin
                    m_trk_ident  <= '0;
                    m_table_full <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // a used mark only on a valid slot
    a_used_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg & ~valid_reg) == '0) else $error("used mark on empty slot");
    // a result never says both new and full
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_new_track && m_table_full)) else $error("flags clash");
    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_trk_ident)))
        else $error("result dropped");
endmodule

/* dv/tb_top.sv */
// tb_top: self-checking testbench for greedy_iou_track_association.
// Predicts track association results per request and compares them in order.
// Depends on gita_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
    localparam int NSLOT = 16;
    localparam int CB    = 12;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic          op;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] w;
        logic [CB-1:0] h;
    } request_t;

    typedef struct packed {
        logic [15:0] id;
        logic        fresh;
        logic        full;
    } assoc_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_idx = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = 1'b0;
    logic [CB-1:0] s_box_x = '0, s_box_y = '0, s_box_w = '0, s_box_h = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_trk_ident;
    logic m_new_track, m_table_full;

    greedy_iou_track_association #(.MAX_TRACKS(NSLOT), .COORD_BITS(CB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_box_x(s_box_x), .s_box_y(s_box_y), .s_box_w(s_box_w), .s_box_h(s_box_h),
        .m_valid(m_valid), .m_ready(m_ready), .m_trk_ident(m_trk_ident),
        .m_new_track(m_new_track), .m_table_full(m_table_full)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor's own copy of the track table and registers.
    logic          trk_valid [NSLOT];
    logic          trk_used  [NSLOT];
    logic [CB-1:0] trk_x [NSLOT], trk_y [NSLOT], trk_w [NSLOT], trk_h [NSLOT];
    logic [8:0]    trk_miss  [NSLOT];
    logic [15:0]   trk_id    [NSLOT];
    logic [15:0]   id_next;
    logic [7:0]    thr_q08;
    logic [7:0]    miss_limit;

    request_t pending_reqs[$];
    assoc_t   expected_assoc[$];
    int       mismatches = 0;
    int       send_idle_pct = 0, recv_idle_pct = 0;
    bit       recv_hold = 1'b0;     // long receiver hold-off
    bit       stim_done = 1'b0;
    int       quiet_cycles = 0;

    function automatic longint unsigned overlap_len(longint unsigned p, longint unsigned lp,
                                                    longint unsigned q, longint unsigned lq);
        longint unsigned s, e;
        s = (p > q) ? p : q;
        e = ((p + lp) < (q + lq)) ? (p + lp) : (q + lq);
        return (e > s) ? e - s : 0;
    endfunction

    // Applies one request to the predicted table; returns 1 if it yields a result.
    function automatic bit associate(request_t r, output assoc_t res);
        longint unsigned area, inter, uni, b_inter, b_uni;
        int best;
        res = '0;
        if (r.op == gita_pkg::OP_EOF) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (trk_valid[i] && !trk_used[i]) begin
                    trk_miss[i] = trk_miss[i] + 9'd1;
                    if (trk_miss[i] > {1'b0, miss_limit}) trk_valid[i] = 1'b0;
                end
                trk_used[i] = 1'b0;
            end
            return 1'b0;
        end
        area = longint'(r.w) * longint'(r.h);
        best = -1; b_inter = 0; b_uni = 1;
        for (int i = 0; i < NSLOT; i++) begin
            if (!trk_valid[i] || trk_used[i]) continue;
            inter = overlap_len(r.x, r.w, trk_x[i], trk_w[i]) *
                    overlap_len(r.y, r.h, trk_y[i], trk_h[i]);
            if (inter == 0) continue;
            uni = area + longint'(trk_w[i]) * longint'(trk_h[i]) - inter;
            // All products stay well inside 64 bits at 12-bit coordinates.
            if (!(inter * 256 > longint'(thr_q08) * uni)) continue;
            if (inter * b_uni > b_inter * uni) begin
                best = i; b_inter = inter; b_uni = uni;
            end
        end
        if (best >= 0) begin
            trk_x[best] = r.x; trk_y[best] = r.y; trk_w[best] = r.w; trk_h[best] = r.h;
            trk_miss[best] = '0;
            trk_used[best] = 1'b1;
            res.id = trk_id[best];
            return 1'b1;
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (!trk_valid[i]) begin
                trk_valid[i] = 1'b1;
                trk_x[i] = r.x; trk_y[i] = r.y; trk_w[i] = r.w; trk_h[i] = r.h;
                trk_miss[i] = '0;
                trk_id[i] = id_next;
                trk_used[i] = 1'b1;
                id_next = id_next + 16'd1;
                res.id = trk_id[i];
                res.fresh = 1'b1;
                return 1'b1;
            end
        end
        res.full = 1'b1;
        return 1'b1;
    endfunction

    // Driver: presents queued requests, holds them until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            assoc_t r;
            if (s_valid) begin
                if (associate({s_op, s_box_x, s_box_y, s_box_w, s_box_h}, r))
                    expected_assoc.insert(expected_assoc.size(), r);
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                request_t q;
                q = pending_reqs[0];
                pending_reqs.delete(0);
                s_valid <= 1'b1;
                s_op <= q.op; s_box_x <= q.x; s_box_y <= q.y;
                s_box_w <= q.w; s_box_h <= q.h;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_assoc.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result id=%0d", m_trk_ident);
                end else begin
                    assoc_t e;
                    e = expected_assoc[0];
                    expected_assoc.delete(0);
                    if (m_trk_ident !== e.id || m_new_track !== e.fresh ||
                        m_table_full !== e.full) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("exp id=%0d new=%0b full=%0b, got id=%0d new=%0b full=%0b",
                                     e.id, e.fresh, e.full, m_trk_ident, m_new_track,
                                     m_table_full);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no request or result accepted.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || stim_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_req(bit op, int x, int y, int w, int h);
        request_t r;
        r.op = op; r.x = CB'(x); r.y = CB'(y); r.w = CB'(w); r.h = CB'(h);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_valid || expected_assoc.size() > 0)
            @(posedge aclk);
        // an end-of-frame request may still be ageing the table
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == gita_pkg::CFG_IOU_THRESHOLD) thr_q08 = val; else miss_limit = val;
    endtask

    // One frame of random detections: mostly jittered copies of live tracks.
    task automatic random_frame(int n);
        for (int k = 0; k < n; k++) begin
            int s, j;
            s = $urandom_range(NSLOT - 1);
            if ($urandom_range(9) < 7 && trk_valid[s]) begin
                j = $urandom_range(4);
                push_req(gita_pkg::OP_DET, (trk_x[s] + j) & 12'hFFF, trk_y[s], trk_w[s],
                         trk_h[s] + j);
            end else if ($urandom_range(9) == 0) begin
                push_req(gita_pkg::OP_DET, $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095));
            end else begin
                push_req(gita_pkg::OP_DET, $urandom_range(3900), $urandom_range(3900),
                         $urandom_range(1, 190), $urandom_range(1, 190));
            end
        end
        push_req(gita_pkg::OP_EOF, $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095), $urandom_range(4095));
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            trk_valid[i] = 1'b0; trk_used[i] = 1'b0; trk_miss[i] = '0; trk_id[i] = '0;
            trk_x[i] = '0; trk_y[i] = '0; trk_w[i] = '0; trk_h[i] = '0;
        end
        id_next = '0;
        thr_q08 = gita_pkg::IOU_THRESHOLD_RST;
        miss_limit = gita_pkg::MAX_MISSED_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero-area boxes, extremes, match, table full, ageing.
        write_reg(gita_pkg::CFG_IOU_THRESHOLD, 8'd0);
        write_reg(gita_pkg::CFG_MAX_MISSED, 8'd0);
        push_req(gita_pkg::OP_DET, 0, 0, 0, 0);
        push_req(gita_pkg::OP_DET, 0, 0, 0, 0);             // zero area never matches
        push_req(gita_pkg::OP_DET, 4095, 4095, 4095, 4095);
        push_req(gita_pkg::OP_DET, 4095, 4095, 4095, 4095); // same box, but slot used
        push_req(gita_pkg::OP_EOF, 0, 0, 0, 0);
        push_req(gita_pkg::OP_DET, 4094, 4094, 4095, 4095); // matches previous track
        for (int i = 0; i < 14; i++) push_req(gita_pkg::OP_DET, i * 200, 0, 100, 100);
        push_req(gita_pkg::OP_DET, 3000, 3000, 50, 50);     // table full
        push_req(gita_pkg::OP_EOF, 4095, 0, 4095, 0);
        push_req(gita_pkg::OP_EOF, 0, 4095, 0, 4095);       // unused tracks dropped
        wait_idle();

        write_reg(gita_pkg::CFG_IOU_THRESHOLD, 8'd255);
        push_req(gita_pkg::OP_DET, 10, 10, 20, 20);
        push_req(gita_pkg::OP_EOF, 0, 0, 0, 0);
        push_req(gita_pkg::OP_DET, 10, 10, 20, 20);         // exact copy clears 255/256
        push_req(gita_pkg::OP_EOF, 0, 0, 0, 0);
        wait_idle();

        // Long receiver hold-off while requests keep coming.
        recv_hold = 1'b1;
        random_frame(6);
        repeat (600) @(posedge aclk);
        recv_hold = 1'b0;
        wait_idle();

        // Random phases with changing idling and settings.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 86 : 0;
            recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 31 : 0;
            write_reg(gita_pkg::CFG_IOU_THRESHOLD,
                      (ph == 2) ? 8'd77 : 8'($urandom_range(255)));
            write_reg(gita_pkg::CFG_MAX_MISSED, (ph == 1) ? 8'd255 : 8'($urandom_range(4)));
            for (int f = 0; f < 30; f++) begin
                random_frame($urandom_range(2, 12));
                if (pending_reqs.size() > 40) wait_idle();
            end
            wait_idle();
        end

        stim_done = 1'b1;
        if (mismatches == 0 && expected_assoc.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/gita_pkg.sv
hw/rtl/greedy_iou_track_association.sv
dv/tb_top.sv
